[design/draw_command_upscale_2x_macros.svh]
// ----------------------------------------------------------------------------
// draw_command_upscale_2x assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DRAW_COMMAND_UPSCALE_2X_MACROS_SVH
`define DRAW_COMMAND_UPSCALE_2X_MACROS_SVH

// Same-cycle implication, masked while reset is low.
`define DCU2X_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dcu2x: same-cycle check failed");

// Next-cycle implication, masked while reset is low.
`define DCU2X_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dcu2x: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define DCU2X_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("dcu2x: reset check failed");

`endif

[design/dcu2x_pkg.sv]
// ----------------------------------------------------------------------------
// dcu2x_pkg
// Command codes, beat types and bit-doubling helper for the 2x upscaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcu2x_pkg;

    // Command codes
    localparam logic [2:0] FN_PIXEL  = 3'd0;
    localparam logic [2:0] FN_SOLID  = 3'd1;
    localparam logic [2:0] FN_FIXED  = 3'd2;
    localparam logic [2:0] FN_BITMAP = 3'd3;
    localparam logic [2:0] FN_CLIP   = 3'd4;
    localparam logic [2:0] FN_DIM    = 3'd5;
    localparam logic [2:0] FN_PASS   = 3'd6;

    // Direction codes
    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd3;

    // Bitmap chunk geometry
    localparam logic [13:0] CHUNK_PIX = 14'd8;
    localparam logic [14:0] CHUNK_LEN = 15'd16;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [14:0] pos_x;
        logic signed [14:0] pos_y;
        logic [13:0]        length;
        logic [1:0]         direction;
        logic [13:0]        chunk_offset;
        logic [7:0]         bitmap_byte;
        logic [14:0]        box_w;
        logic [14:0]        box_h;
    } t_cmd;

    typedef struct packed {
        logic [2:0]         out_func;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic [14:0]        out_length;
        logic [1:0]         out_direction;
        logic [15:0]        out_bitmap;
        logic [15:0]        out_w;
        logic [15:0]        out_h;
        logic               last;
    } t_res;

    // Per-beat control from the expander
    typedef struct packed {
        logic emit;   // this beat produces a result
        logic done;   // this beat retires the held command
    } t_beat_ctl;

    function automatic logic [15:0] double_bits(input logic [7:0] b);
        logic [15:0] r;
        for (int k = 0; k < 8; k++) begin
            r[2*k]   = b[k];
            r[2*k+1] = b[k];
        end
        return r;
    endfunction

endpackage

[design/dcu2x_if.sv]
// ----------------------------------------------------------------------------
// dcu2x_cmd_if / dcu2x_res_if
// Valid/ready channels for logical commands in and physical commands out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dcu2x_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [14:0] pos_x;
    logic signed [14:0] pos_y;
    logic [13:0]        length;
    logic [1:0]         direction;
    logic [13:0]        chunk_offset;
    logic [7:0]         bitmap_byte;
    logic [14:0]        box_w;
    logic [14:0]        box_h;

    modport source (
        output valid, func, pos_x, pos_y, length, direction, chunk_offset,
               bitmap_byte, box_w, box_h,
        input  ready
    );
    modport sink (
        input  valid, func, pos_x, pos_y, length, direction, chunk_offset,
               bitmap_byte, box_w, box_h,
        output ready
    );
endinterface

interface dcu2x_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         out_func;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [14:0]        out_length;
    logic [1:0]         out_direction;
    logic [15:0]        out_bitmap;
    logic [15:0]        out_w;
    logic [15:0]        out_h;
    logic               last;

    modport source (
        output valid, out_func, out_x, out_y, out_length, out_direction,
               out_bitmap, out_w, out_h, last,
        input  ready
    );
    modport sink (
        input  valid, out_func, out_x, out_y, out_length, out_direction,
               out_bitmap, out_w, out_h, last,
        output ready
    );
endinterface

[design/draw_command_upscale_2x.sv]
// ----------------------------------------------------------------------------
// draw_command_upscale_2x
// 2x nearest-neighbor scaler for a stream of drawing commands. A pixel
// becomes four pixels, a solid or fixed line two lines of doubled length,
// a bitmap chunk two lines with a bit-doubled 16-bit bitmap (a chunk that
// starts at or past the end of its run is dropped), a clip box is doubled,
// a dimension reply halved, anything else forwarded. Every result carries
// last on the final beat of its command. Rate: the result register takes
// one beat per cycle while the downstream is ready; the input stage holds
// a command until its last beat is done, a dropped chunk for its single
// empty beat, and takes a new one in the cycle that last beat leaves it.
// Accepted commands are registered in the input stage, their beats in the
// result register. Coordinates wrap to min(COORD_WIDTH, 18) bits two's
// complement, sign-extended (or truncated) in the 16-bit output fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module draw_command_upscale_2x
    import dcu2x_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dcu2x_cmd_if.sink   i_cmd,
    dcu2x_res_if.source o_res
);

    // Input stage: held command and its beat counter
    logic       r_in_valid, n_in_valid;
    t_cmd       r_in;
    logic [1:0] r_beat, n_beat;

    t_res       beat_res;
    t_beat_ctl  beat_ctl;
    logic       out_space;
    logic       advance;
    logic       accept;

    // Advance the held command when its beat lands in the result register,
    // or at once when the beat produces nothing.
    assign advance     = r_in_valid & (~beat_ctl.emit | out_space);
    assign i_cmd.ready = ~r_in_valid | (advance & beat_ctl.done);
    assign accept      = i_cmd.valid & i_cmd.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        n_beat     = r_beat;
        if (advance) begin
            if (beat_ctl.done) begin
                n_in_valid = 1'b0;
                n_beat     = 2'd0;
            end else begin
                n_beat = r_beat + 2'd1;
            end
        end
        if (accept) begin
            n_in_valid = 1'b1;
            n_beat     = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_beat     <= 2'd0;
        end else begin
            r_in_valid <= n_in_valid;
            r_beat     <= n_beat;
        end
    end

    // Capture the command payload on accept; no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.func         <= i_cmd.func;
            r_in.pos_x        <= i_cmd.pos_x;
            r_in.pos_y        <= i_cmd.pos_y;
            r_in.length       <= i_cmd.length;
            r_in.direction    <= i_cmd.direction;
            r_in.chunk_offset <= i_cmd.chunk_offset;
            r_in.bitmap_byte  <= i_cmd.bitmap_byte;
            r_in.box_w        <= i_cmd.box_w;
            r_in.box_h        <= i_cmd.box_h;
        end
    end

    // Build the physical command for the current beat
    dcu2x_expand #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_expand (
        .i_cmd  (r_in),
        .i_beat (r_beat),
        .o_res  (beat_res),
        .o_ctl  (beat_ctl)
    );

    // Result register toward the display driver
    dcu2x_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid & beat_ctl.emit),
        .i_res   (beat_res),
        .o_space (out_space),
        .o_res   (o_res)
    );

endmodule

[design/dcu2x_expand.sv]
// ----------------------------------------------------------------------------
// dcu2x_expand
// Builds the physical command for one beat of a held logical command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcu2x_expand
    import dcu2x_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  t_cmd      i_cmd,
    input  logic [1:0] i_beat,
    output t_res      o_res,
    output t_beat_ctl o_ctl
);

    // Exact coordinates fit in 18 signed bits
    localparam int EXACT_W = 18;
    localparam int WRAP_W  = (COORD_WIDTH < EXACT_W) ? COORD_WIDTH : EXACT_W;

    function automatic logic [15:0] wrap_coord(input logic [EXACT_W-1:0] v);
        logic [EXACT_W-1:0] s;
        s = EXACT_W'($signed(v[WRAP_W-1:0]));
        return s[15:0];
    endfunction

    logic signed [16:0]   sx, sy;
    logic signed [16:0]   offs;
    logic [EXACT_W-1:0]   ex, ey;
    logic                 addx, addy;
    logic [13:0]          rem;
    logic                 drop;

    assign offs = $signed({3'd0, i_cmd.chunk_offset});
    assign rem  = i_cmd.length - i_cmd.chunk_offset;
    assign drop = (i_cmd.func == FN_BITMAP) && (i_cmd.chunk_offset >= i_cmd.length);

    // Chunk start moves along the line direction
    always_comb begin
        sx = 17'(i_cmd.pos_x);
        sy = 17'(i_cmd.pos_y);
        if (i_cmd.func == FN_BITMAP) begin
            unique case (i_cmd.direction)
                DIR_RIGHT: sx = 17'(i_cmd.pos_x) + offs;
                DIR_DOWN:  sy = 17'(i_cmd.pos_y) + offs;
                DIR_LEFT:  sx = 17'(i_cmd.pos_x) - offs;
                DIR_UP:    sy = 17'(i_cmd.pos_y) - offs;
                default:   sx = 17'(i_cmd.pos_x);
            endcase
        end
    end

    // Corner or cross offset for this beat
    always_comb begin
        if (i_cmd.func == FN_PIXEL) begin
            addx = i_beat[0] ^ i_beat[1];
            addy = i_beat[1];
        end else begin
            addx = i_beat[0] &  i_cmd.direction[0];
            addy = i_beat[0] & ~i_cmd.direction[0];
        end
    end

    assign ex = EXACT_W'({sx, 1'b0}) + {{(EXACT_W-1){1'b0}}, addx};
    assign ey = EXACT_W'({sy, 1'b0}) + {{(EXACT_W-1){1'b0}}, addy};

    always_comb begin
        o_res               = '0;
        o_res.out_func      = i_cmd.func;
        o_res.out_direction = i_cmd.direction;
        o_ctl.emit          = 1'b1;
        o_ctl.done          = 1'b1;
        unique case (i_cmd.func) inside
            FN_PIXEL: begin
                o_res.out_x = wrap_coord(ex);
                o_res.out_y = wrap_coord(ey);
                o_ctl.done  = (i_beat == 2'd3);
            end
            FN_SOLID, FN_FIXED: begin
                o_res.out_x      = wrap_coord(ex);
                o_res.out_y      = wrap_coord(ey);
                o_res.out_length = {i_cmd.length, 1'b0};
                o_ctl.done       = i_beat[0];
            end
            FN_BITMAP: begin
                o_res.out_x      = wrap_coord(ex);
                o_res.out_y      = wrap_coord(ey);
                o_res.out_length = (rem >= CHUNK_PIX) ? CHUNK_LEN : {rem, 1'b0};
                o_res.out_bitmap = double_bits(i_cmd.bitmap_byte);
                o_ctl.done       = i_beat[0] | drop;
                o_ctl.emit       = ~drop;
            end
            FN_CLIP: begin
                o_res.out_x = wrap_coord(ex);
                o_res.out_y = wrap_coord(ey);
                o_res.out_w = {i_cmd.box_w, 1'b0};
                o_res.out_h = {i_cmd.box_h, 1'b0};
            end
            FN_DIM: begin
                o_res.out_w = {2'd0, i_cmd.box_w[14:1]};
                o_res.out_h = {2'd0, i_cmd.box_h[14:1]};
            end
            default: begin
                // Passthrough and undefined codes: forward fields as they are
                o_res.out_x      = wrap_coord(EXACT_W'(i_cmd.pos_x));
                o_res.out_y      = wrap_coord(EXACT_W'(i_cmd.pos_y));
                o_res.out_length = {1'b0, i_cmd.length};
                o_res.out_bitmap = {8'd0, i_cmd.bitmap_byte};
                o_res.out_w      = {1'b0, i_cmd.box_w};
                o_res.out_h      = {1'b0, i_cmd.box_h};
            end
        endcase
        o_res.last = o_ctl.done;
    end

endmodule

[design/dcu2x_out_reg.sv]
// ----------------------------------------------------------------------------
// dcu2x_out_reg
// Result register on the downstream channel; loads when empty or draining.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcu2x_out_reg
    import dcu2x_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_res        i_res,
    output logic        o_space,
    dcu2x_res_if.source o_res
);

    logic r_valid, n_valid;
    t_res r_res;
    logic load;

    assign o_space = ~r_valid | o_res.ready;
    assign load    = i_valid & o_space;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (o_res.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.out_func      = r_res.out_func;
    assign o_res.out_x         = r_res.out_x;
    assign o_res.out_y         = r_res.out_y;
    assign o_res.out_length    = r_res.out_length;
    assign o_res.out_direction = r_res.out_direction;
    assign o_res.out_bitmap    = r_res.out_bitmap;
    assign o_res.out_w         = r_res.out_w;
    assign o_res.out_h         = r_res.out_h;
    assign o_res.last          = r_res.last;

endmodule

[design/dcu2x_checker.sv]
// ----------------------------------------------------------------------------
// dcu2x_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "draw_command_upscale_2x_macros.svh"

module dcu2x_checker
    import dcu2x_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_res_valid,
    input logic               i_res_ready,
    input logic [2:0]         i_out_func,
    input logic signed [15:0] i_out_x,
    input logic signed [15:0] i_out_y,
    input logic [14:0]        i_out_length,
    input logic               i_last
);

    logic stalled;
    assign stalled = i_res_valid & ~i_res_ready;

    // Hold a stalled beat with its function, position and last flag
    `DCU2X_ASSERT_NEXT(a_hold_beat, i_clk, i_rst_n, stalled, i_res_valid && $stable(i_out_func) && $stable(i_out_x) && $stable(i_out_y) && $stable(i_last))

    // No beat right after a reset cycle
    `DCU2X_ASSERT_NEXT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n, !i_res_valid)

    // A dimension reply carries no position or length
    `DCU2X_ASSERT_NOW(a_dim_zero, i_clk, i_rst_n, i_res_valid && (i_out_func == FN_DIM), (i_out_x == 16'sd0) && (i_out_y == 16'sd0) && (i_out_length == 15'd0) && i_last)

    // A bitmap beat draws between 2 and 16 physical pixels
    `DCU2X_ASSERT_NOW(a_chunk_len, i_clk, i_rst_n, i_res_valid && (i_out_func == FN_BITMAP), (i_out_length != 15'd0) && (i_out_length <= CHUNK_LEN))

endmodule

bind draw_command_upscale_2x dcu2x_checker u_dcu2x_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_out_func   (o_res.out_func),
    .i_out_x      (o_res.out_x),
    .i_out_y      (o_res.out_y),
    .i_out_length (o_res.out_length),
    .i_last       (o_res.last)
);
